// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PP_CHECK_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define PP_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/pp_pkg.sv -----
// ----------------------------------------------------------------------------
// pp_pkg
// shared types, constants and helpers of the point projector
// ----------------------------------------------------------------------------
package pp_pkg;

    localparam int Q_W    = 64;           // internal signed q.32 word
    localparam int Q_FRAC = 32;
    localparam int MAG_W  = 62;           // magnitude bits below the saturation limit
    localparam int LO_W   = 32;           // low partial-product slice
    localparam int HI_W   = MAG_W - LO_W; // high partial-product slice
    localparam int PRE_SHIFT = MAG_W - Q_FRAC;
    localparam int MUL_LAT = 5;
    localparam int DIV_LAT = MAG_W + 3;
    localparam int CFG_W  = 32;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t Q_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;
    localparam logic signed [Q_W:0] SUM_LIM = 65'sh0_3FFF_FFFF_FFFF_FFFF;

    localparam logic [CFG_W-1:0] FOCAL_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_RADIAL_K1 = 3'd4,
        REG_RADIAL_K2 = 3'd5,
        REG_TANG_P1   = 3'd6,
        REG_TANG_P2   = 3'd7
    } cfg_reg_t;

    // saturating add to +-(2^62 - 1)
    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [Q_W:0] s;
        s = $signed({a[Q_W-1], a}) + $signed({b[Q_W-1], b});
        if (s > SUM_LIM) begin
            return Q_LIM;
        end
        else if (s < -SUM_LIM) begin
            return -Q_LIM;
        end
        return s[Q_W-1:0];
    endfunction

endpackage

// ----- hdl/pp_point_if.sv -----
// ----------------------------------------------------------------------------
// pp_point_if
// input channel: one camera-frame point per transaction
// ----------------------------------------------------------------------------
interface pp_point_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

// ----- hdl/pp_pixel_if.sv -----
// ----------------------------------------------------------------------------
// pp_pixel_if
// output channel: one projected pixel per transaction
// ----------------------------------------------------------------------------
interface pp_pixel_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pixel_u;
    logic signed [COORD_WIDTH-1:0] pixel_v;
    logic                          invalid;

    modport source (output valid, output pixel_u, output pixel_v, output invalid,
                    input ready);
    modport sink   (input valid, input pixel_u, input pixel_v, input invalid,
                    output ready);
endinterface

// ----- hdl/pp_delay.sv -----
// ----------------------------------------------------------------------------
// pp_delay
// enabled shift line that keeps side data aligned with the datapath
// ----------------------------------------------------------------------------
module pp_delay #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 5
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

// ----- hdl/pp_mul.sv -----
// ----------------------------------------------------------------------------
// pp_mul
// pipelined q.32 multiply, truncation toward zero, saturation to +-(2^62-1)
// ----------------------------------------------------------------------------
module pp_mul (
    input  logic        clk,
    input  logic        en,
    input  pp_pkg::q_t  a,
    input  pp_pkg::q_t  b,
    output pp_pkg::q_t  p
);
    import pp_pkg::*;

    logic [Q_W-1:0]         abs_a;
    logic [Q_W-1:0]         abs_b;
    logic [MAG_W-1:0]       ma_reg;
    logic [MAG_W-1:0]       mb_reg;
    logic                   neg1_reg;
    logic                   neg2_reg;
    logic                   neg3_reg;
    logic                   neg4_reg;
    logic [2*LO_W-1:0]      ll_reg;
    logic [LO_W+HI_W-1:0]   lh_reg;
    logic [LO_W+HI_W-1:0]   hl_reg;
    logic [2*HI_W-1:0]      hh_reg;
    logic [2*HI_W-1:0]      hh3_reg;
    logic [Q_W-1:0]         mid_reg;
    logic [2*HI_W+LO_W:0]   sum;
    logic [MAG_W-1:0]       m_next;
    logic [MAG_W-1:0]       m_reg;
    q_t                     p_reg;

    assign abs_a = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
    assign abs_b = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);

    // product >> 32 = hh << 32 + mid
    assign sum    = {hh3_reg, {LO_W{1'b0}}} + (2*HI_W+LO_W+1)'(mid_reg);
    assign m_next = (|sum[2*HI_W+LO_W:MAG_W]) ? Q_LIM[MAG_W-1:0] : sum[MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= abs_a[MAG_W-1:0];
            mb_reg   <= abs_b[MAG_W-1:0];
            neg1_reg <= a[Q_W-1] ^ b[Q_W-1];

            ll_reg   <= ma_reg[LO_W-1:0] * mb_reg[LO_W-1:0];
            lh_reg   <= ma_reg[LO_W-1:0] * mb_reg[MAG_W-1:LO_W];
            hl_reg   <= ma_reg[MAG_W-1:LO_W] * mb_reg[LO_W-1:0];
            hh_reg   <= ma_reg[MAG_W-1:LO_W] * mb_reg[MAG_W-1:LO_W];
            neg2_reg <= neg1_reg;

            mid_reg  <= Q_W'(ll_reg[2*LO_W-1:LO_W]) + Q_W'(lh_reg) + Q_W'(hl_reg);
            hh3_reg  <= hh_reg;
            neg3_reg <= neg2_reg;

            m_reg    <= m_next;
            neg4_reg <= neg3_reg;

            p_reg    <= neg4_reg ? -$signed({{(Q_W-MAG_W){1'b0}}, m_reg})
                                 :  $signed({{(Q_W-MAG_W){1'b0}}, m_reg});
        end
    end

    assign p = p_reg;
endmodule

// ----- hdl/pp_div.sv -----
// ----------------------------------------------------------------------------
// pp_div
// pipelined restoring divider, two quotients over one shared depth
// ----------------------------------------------------------------------------
module pp_div #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] num_x,
    input  logic signed [COORD_WIDTH-1:0] num_y,
    input  logic signed [COORD_WIDTH-1:0] den,
    output pp_pkg::q_t                    quo_x,
    output pp_pkg::q_t                    quo_y
);
    import pp_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [CW-1:0]        ux_reg;
    logic [CW-1:0]        uy_reg;
    logic [CW-1:0]        ud_reg;
    logic                 nx_reg;
    logic                 ny_reg;

    // iteration registers, entry 0 is the setup stage
    logic [CW-1:0]        rx_reg [0:MAG_W];
    logic [CW-1:0]        ry_reg [0:MAG_W];
    logic [MAG_W-1:0]     qx_reg [0:MAG_W];
    logic [MAG_W-1:0]     qy_reg [0:MAG_W];
    logic [CW-1:0]        d_reg  [0:MAG_W];
    logic [PRE_SHIFT-1:0] lx_reg [0:MAG_W];
    logic [PRE_SHIFT-1:0] ly_reg [0:MAG_W];
    logic                 ox_reg [0:MAG_W];
    logic                 oy_reg [0:MAG_W];
    logic                 sx_reg [0:MAG_W];
    logic                 sy_reg [0:MAG_W];

    q_t                   quo_x_reg;
    q_t                   quo_y_reg;
    logic [MAG_W-1:0]     mx;
    logic [MAG_W-1:0]     my;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= num_x[CW-1] ? $unsigned(-num_x) : $unsigned(num_x);
            uy_reg <= num_y[CW-1] ? $unsigned(-num_y) : $unsigned(num_y);
            ud_reg <= den[CW-1] ? $unsigned(-den) : $unsigned(den);
            nx_reg <= num_x[CW-1] ^ den[CW-1];
            ny_reg <= num_y[CW-1] ^ den[CW-1];

            // quotient of 2^62 or more saturates
            ox_reg[0] <= (CW+PRE_SHIFT)'(ux_reg) >= {ud_reg, {PRE_SHIFT{1'b0}}};
            oy_reg[0] <= (CW+PRE_SHIFT)'(uy_reg) >= {ud_reg, {PRE_SHIFT{1'b0}}};
            rx_reg[0] <= CW'(ux_reg >> PRE_SHIFT);
            ry_reg[0] <= CW'(uy_reg >> PRE_SHIFT);
            lx_reg[0] <= PRE_SHIFT'(ux_reg);
            ly_reg[0] <= PRE_SHIFT'(uy_reg);
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            d_reg[0]  <= ud_reg;
            sx_reg[0] <= nx_reg;
            sy_reg[0] <= ny_reg;
        end
    end

    for (genvar j = 0; j < MAG_W; j++)
    begin : g_step
        localparam int QB = MAG_W - 1 - j;
        logic          bx;
        logic          by;
        logic [CW-1:0] tx;
        logic [CW-1:0] ty;
        logic          gx;
        logic          gy;

        if (QB >= Q_FRAC)
        begin : g_num
            assign bx = lx_reg[j][QB-Q_FRAC];
            assign by = ly_reg[j][QB-Q_FRAC];
        end
        else
        begin : g_zero
            assign bx = 1'b0;
            assign by = 1'b0;
        end

        assign tx = {rx_reg[j][CW-2:0], bx};
        assign ty = {ry_reg[j][CW-2:0], by};
        assign gx = tx >= d_reg[j];
        assign gy = ty >= d_reg[j];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[j+1] <= gx ? tx - d_reg[j] : tx;
                ry_reg[j+1] <= gy ? ty - d_reg[j] : ty;
                qx_reg[j+1] <= {qx_reg[j][MAG_W-2:0], gx};
                qy_reg[j+1] <= {qy_reg[j][MAG_W-2:0], gy};
                d_reg[j+1]  <= d_reg[j];
                lx_reg[j+1] <= lx_reg[j];
                ly_reg[j+1] <= ly_reg[j];
                ox_reg[j+1] <= ox_reg[j];
                oy_reg[j+1] <= oy_reg[j];
                sx_reg[j+1] <= sx_reg[j];
                sy_reg[j+1] <= sy_reg[j];
            end
        end
    end

    assign mx = ox_reg[MAG_W] ? Q_LIM[MAG_W-1:0] : qx_reg[MAG_W];
    assign my = oy_reg[MAG_W] ? Q_LIM[MAG_W-1:0] : qy_reg[MAG_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_x_reg <= sx_reg[MAG_W] ? -$signed({{(Q_W-MAG_W){1'b0}}, mx})
                                       :  $signed({{(Q_W-MAG_W){1'b0}}, mx});
            quo_y_reg <= sy_reg[MAG_W] ? -$signed({{(Q_W-MAG_W){1'b0}}, my})
                                       :  $signed({{(Q_W-MAG_W){1'b0}}, my});
        end
    end

    assign quo_x = quo_x_reg;
    assign quo_y = quo_y_reg;
endmodule

// ----- hdl/pinhole_radtan_point_projector.sv -----
// ----------------------------------------------------------------------------
// pinhole_radtan_point_projector
// pinhole projection with two-term radial and tangential lens distortion
// ----------------------------------------------------------------------------
// Accepts one camera-frame point per clock while input ready is high and
// returns one pixel per point, in order. The pipeline is made of the
// 62-step divider that forms x/z and y/z, followed by five chained
// multiplier pipelines and seven add stages.
// The whole pipeline advances together; a two-entry output buffer lets one
// finished pixel wait while the next one arrives, and input ready drops only
// when both entries are full. Zero depth sets invalid and forces both pixels
// to zero. Configuration registers may be written only while no point is in
// flight; they are read live by the stages that use them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pinhole_radtan_point_projector #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  pp_pkg::cfg_reg_t             cfg_index,
    input  logic [pp_pkg::CFG_W-1:0]     cfg_data,
    pp_point_if.sink                     points,
    pp_pixel_if.source                   pixels
);
    import pp_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int PIPE_LAT = DIV_LAT + 5 * MUL_LAT + 7;
    localparam logic signed [Q_W:0] PIX_MAX = (65'sd1 <<< (CW - 1)) - 65'sd1;
    localparam logic signed [Q_W:0] PIX_MIN = -(65'sd1 <<< (CW - 1));

    // configuration
    logic [CFG_W-1:0] fx_reg;
    logic [CFG_W-1:0] fy_reg;
    logic [CFG_W-1:0] cx_reg;
    logic [CFG_W-1:0] cy_reg;
    logic [CFG_W-1:0] k1_reg;
    logic [CFG_W-1:0] k2_reg;
    logic [CFG_W-1:0] p1_reg;
    logic [CFG_W-1:0] p2_reg;

    // coefficients widened from q4.28 to q.32
    q_t k1_q;
    q_t k2_q;
    q_t p1_q;
    q_t p2_q;
    q_t p1_x2;
    q_t p2_x2;

    // flow control
    logic                en;
    logic                push;
    logic                pop;
    logic [PIPE_LAT-1:0] valid_reg;
    logic [1:0]          cnt_reg;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [CW-1:0]       fu_reg [0:1];
    logic [CW-1:0]       fv_reg [0:1];
    logic                fi_reg [0:1];

    // datapath
    logic zero_in;
    logic zero_dly;
    q_t xn, yn, xn1, yn1;
    q_t x2, y2, xy;
    q_t r2_reg, tx_reg, ty_reg, xy_a1_reg, xn_a1_reg, yn_a1_reg;
    q_t sx_reg, sy_reg, r2_a2_reg, xy_a2_reg, xn_a2_reg, yn_a2_reg;
    q_t r4, kr, pxy1, pxy2, qx, qy, xn2, yn2;
    q_t c1_reg, r4_a3_reg, c1d, k2r4;
    q_t pxy1_3, pxy2_3, qx_3, qy_3, xn_3, yn_3;
    q_t c_reg, xn_a4_reg, yn_a4_reg;
    q_t pxy1_4, pxy2_4, qx_4, qy_4;
    q_t xnc, ync;
    q_t ex_reg, ey_reg, qx_a5_reg, qy_a5_reg;
    q_t xd_reg, yd_reg;
    q_t fxd, fyd;
    logic signed [Q_W:0] su;
    logic signed [Q_W:0] sv;
    logic [CW-1:0]       u_reg;
    logic [CW-1:0]       v_reg;
    logic                inv_reg;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= FOCAL_RESET;
            fy_reg <= FOCAL_RESET;
            cx_reg <= '0;
            cy_reg <= '0;
            k1_reg <= '0;
            k2_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOCAL_X:   fx_reg <= cfg_data;
                REG_FOCAL_Y:   fy_reg <= cfg_data;
                REG_CENTER_X:  cx_reg <= cfg_data;
                REG_CENTER_Y:  cy_reg <= cfg_data;
                REG_RADIAL_K1: k1_reg <= cfg_data;
                REG_RADIAL_K2: k2_reg <= cfg_data;
                REG_TANG_P1:   p1_reg <= cfg_data;
                REG_TANG_P2:   p2_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign k1_q  = {{28{k1_reg[31]}}, k1_reg, 4'b0};
    assign k2_q  = {{28{k2_reg[31]}}, k2_reg, 4'b0};
    assign p1_q  = {{28{p1_reg[31]}}, p1_reg, 4'b0};
    assign p2_q  = {{28{p2_reg[31]}}, p2_reg, 4'b0};
    assign p1_x2 = {{27{p1_reg[31]}}, p1_reg, 5'b0};
    assign p2_x2 = {{27{p2_reg[31]}}, p2_reg, 5'b0};

    // ------------------------------------------------------------------
    // flow control: pipeline moves as one unless the output buffer is full
    // ------------------------------------------------------------------
    assign en           = (cnt_reg != 2'd2);
    assign points.ready = en;
    assign push         = en && valid_reg[PIPE_LAT-1];
    assign pop          = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[PIPE_LAT-2:0], points.valid};
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fu_reg[wr_ptr_reg] <= u_reg;
            fv_reg[wr_ptr_reg] <= v_reg;
            fi_reg[wr_ptr_reg] <= inv_reg;
        end
    end

    assign pixels.valid   = (cnt_reg != 2'd0);
    assign pixels.pixel_u = fu_reg[rd_ptr_reg];
    assign pixels.pixel_v = fv_reg[rd_ptr_reg];
    assign pixels.invalid = fi_reg[rd_ptr_reg];

    // ------------------------------------------------------------------
    // perspective divide
    // ------------------------------------------------------------------
    assign zero_in = (points.point_z == '0);

    pp_delay #(.WIDTH(1), .DEPTH(PIPE_LAT - 1)) u_zero_dly (
        .clk (clk), .en (en), .d (zero_in), .q (zero_dly)
    );

    pp_div #(.COORD_WIDTH(CW)) u_div (
        .clk   (clk),
        .en    (en),
        .num_x (points.point_x),
        .num_y (points.point_y),
        .den   (points.point_z),
        .quo_x (xn),
        .quo_y (yn)
    );

    // ------------------------------------------------------------------
    // squares and cross term
    // ------------------------------------------------------------------
    pp_mul u_mul_x2 (.clk (clk), .en (en), .a (xn), .b (xn), .p (x2));
    pp_mul u_mul_y2 (.clk (clk), .en (en), .a (yn), .b (yn), .p (y2));
    pp_mul u_mul_xy (.clk (clk), .en (en), .a (xn), .b (yn), .p (xy));

    pp_delay #(.WIDTH(2 * Q_W), .DEPTH(MUL_LAT)) u_dly_m1 (
        .clk (clk), .en (en), .d ({xn, yn}), .q ({xn1, yn1})
    );

    // r2 and the doubled squares, then r2 + 2x^2 and r2 + 2y^2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg    <= sat_add(x2, y2);
            tx_reg    <= sat_add(x2, x2);
            ty_reg    <= sat_add(y2, y2);
            xy_a1_reg <= xy;
            xn_a1_reg <= xn1;
            yn_a1_reg <= yn1;

            sx_reg    <= sat_add(r2_reg, tx_reg);
            sy_reg    <= sat_add(r2_reg, ty_reg);
            r2_a2_reg <= r2_reg;
            xy_a2_reg <= xy_a1_reg;
            xn_a2_reg <= xn_a1_reg;
            yn_a2_reg <= yn_a1_reg;
        end
    end

    // ------------------------------------------------------------------
    // r4, radial and tangential products
    // ------------------------------------------------------------------
    pp_mul u_mul_r4   (.clk (clk), .en (en), .a (r2_a2_reg), .b (r2_a2_reg), .p (r4));
    pp_mul u_mul_kr   (.clk (clk), .en (en), .a (k1_q),      .b (r2_a2_reg), .p (kr));
    pp_mul u_mul_pxy1 (.clk (clk), .en (en), .a (p1_x2),     .b (xy_a2_reg), .p (pxy1));
    pp_mul u_mul_pxy2 (.clk (clk), .en (en), .a (p2_x2),     .b (xy_a2_reg), .p (pxy2));
    pp_mul u_mul_qx   (.clk (clk), .en (en), .a (p2_q),      .b (sx_reg),    .p (qx));
    pp_mul u_mul_qy   (.clk (clk), .en (en), .a (p1_q),      .b (sy_reg),    .p (qy));

    pp_delay #(.WIDTH(2 * Q_W), .DEPTH(MUL_LAT)) u_dly_m2 (
        .clk (clk), .en (en), .d ({xn_a2_reg, yn_a2_reg}), .q ({xn2, yn2})
    );

    // side terms ride past the c1 stage and the k2*r4 multiply
    pp_delay #(.WIDTH(6 * Q_W), .DEPTH(MUL_LAT + 1)) u_dly_m3 (
        .clk (clk),
        .en  (en),
        .d   ({pxy1, pxy2, qx, qy, xn2, yn2}),
        .q   ({pxy1_3, pxy2_3, qx_3, qy_3, xn_3, yn_3})
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg    <= sat_add(Q_ONE, kr);
            r4_a3_reg <= r4;
        end
    end

    pp_mul u_mul_k2r4 (.clk (clk), .en (en), .a (k2_q), .b (r4_a3_reg), .p (k2r4));

    pp_delay #(.WIDTH(Q_W), .DEPTH(MUL_LAT)) u_dly_c1 (
        .clk (clk), .en (en), .d (c1_reg), .q (c1d)
    );

    // ------------------------------------------------------------------
    // radial factor c and the scaled normalized point
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg     <= sat_add(c1d, k2r4);
            xn_a4_reg <= xn_3;
            yn_a4_reg <= yn_3;
        end
    end

    pp_delay #(.WIDTH(4 * Q_W), .DEPTH(MUL_LAT + 1)) u_dly_m4 (
        .clk (clk),
        .en  (en),
        .d   ({pxy1_3, pxy2_3, qx_3, qy_3}),
        .q   ({pxy1_4, pxy2_4, qx_4, qy_4})
    );

    pp_mul u_mul_xnc (.clk (clk), .en (en), .a (xn_a4_reg), .b (c_reg), .p (xnc));
    pp_mul u_mul_ync (.clk (clk), .en (en), .a (yn_a4_reg), .b (c_reg), .p (ync));

    // distorted point, summed left to right
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg    <= sat_add(xnc, pxy1_4);
            ey_reg    <= sat_add(ync, pxy2_4);
            qx_a5_reg <= qx_4;
            qy_a5_reg <= qy_4;

            xd_reg    <= sat_add(ex_reg, qx_a5_reg);
            yd_reg    <= sat_add(ey_reg, qy_a5_reg);
        end
    end

    // ------------------------------------------------------------------
    // intrinsics and output clamp
    // ------------------------------------------------------------------
    pp_mul u_mul_fx (.clk (clk), .en (en), .a ({32'b0, fx_reg}), .b (xd_reg), .p (fxd));
    pp_mul u_mul_fy (.clk (clk), .en (en), .a ({32'b0, fy_reg}), .b (yd_reg), .p (fyd));

    // sum stays well inside 65 bits, so one clamp covers both limits
    assign su = $signed({fxd[Q_W-1], fxd}) + $signed({33'b0, cx_reg});
    assign sv = $signed({fyd[Q_W-1], fyd}) + $signed({33'b0, cy_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg <= zero_dly;
            if (zero_dly)
            begin
                u_reg <= '0;
                v_reg <= '0;
            end
            else
            begin
                u_reg <= (su > PIX_MAX) ? PIX_MAX[CW-1:0] :
                         (su < PIX_MIN) ? PIX_MIN[CW-1:0] : su[CW-1:0];
                v_reg <= (sv > PIX_MAX) ? PIX_MAX[CW-1:0] :
                         (sv < PIX_MIN) ? PIX_MIN[CW-1:0] : sv[CW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `PP_CHECK_IMP(a_invalid_zero, pixels.valid && pixels.invalid, pixels.pixel_u == '0 && pixels.pixel_v == '0)
    `PP_CHECK_IMP(a_stall_has_output, !points.ready, pixels.valid)
    `PP_CHECK_NEXT(a_pop_frees_input, pop && !push, points.ready)
    `PP_CHECK_NEXT(a_push_shows_output, push && !pop, pixels.valid)

endmodule
